// ===== rtl/matrix_rotate_flip_engine_assert.svh =====
`ifndef MATRIX_ROTATE_FLIP_ENGINE_ASSERT_SVH
`define MATRIX_ROTATE_FLIP_ENGINE_ASSERT_SVH
// Assertion macros for the matrix rotate and flip engine.
// Both sample on clk_i and are switched off while rst_ni is low.

// The consequent must hold in the same cycle as the antecedent.
`define MRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mrf_pkg.sv =====
// Shared types and constants of the matrix rotate and flip engine.
package mrf_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned XF_W      = 3;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ORI_W     = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
  localparam logic [OP_W-1:0] OP_TRANSFORM = 2'd1;
  localparam logic [OP_W-1:0] OP_READ      = 2'd2;

  // Transform codes.
  localparam logic [XF_W-1:0] XF_REV_ROWS = 3'd0;
  localparam logic [XF_W-1:0] XF_REV_COLS = 3'd1;
  localparam logic [XF_W-1:0] XF_ROT90    = 3'd2;
  localparam logic [XF_W-1:0] XF_ROT180   = 3'd3;
  localparam logic [XF_W-1:0] XF_ROT270   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Orientation bits: column flip, row flip, transpose.
  localparam int unsigned ORI_FC = 0;
  localparam int unsigned ORI_FR = 1;
  localparam int unsigned ORI_T  = 2;
  localparam logic [ORI_W-1:0] ORI_M_FC = 3'b001;
  localparam logic [ORI_W-1:0] ORI_M_FR = 3'b010;
  localparam logic [ORI_W-1:0] ORI_M_T  = 3'b100;

  // Command queue geometry.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Per-command control carried from the front end to the back end.
  typedef struct packed {
    logic             is_read;
    logic             last;
    logic [DIM_W-1:0] out_rows;
    logic [DIM_W-1:0] out_cols;
  } mrf_meta_t;

  localparam int unsigned META_W = $bits(mrf_meta_t);

  typedef struct packed {
    logic full;
    logic empty;
  } mrf_q_stat_t;

endpackage

// ===== rtl/mrf_if.sv =====
// Valid/ready channel interfaces for items and results.
interface mrf_in_if import mrf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [XF_W-1:0]           transform;

  modport source (output valid, operation, value, transform, input ready);
  modport sink   (input valid, operation, value, transform, output ready);
endinterface

interface mrf_out_if import mrf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;
  logic                     last;
  logic [DIM_W-1:0]         out_rows;
  logic [DIM_W-1:0]         out_cols;

  modport source (output valid, element, last, out_rows, out_cols, input ready);
  modport sink   (input valid, element, last, out_rows, out_cols, output ready);
endinterface

// ===== rtl/mrf_queue.sv =====
// Two-entry command queue between the front end and the back end.
module mrf_queue import mrf_pkg::*; #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output mrf_q_stat_t      stat_o
);

  logic [WIDTH-1:0]   slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/mrf_front.sv =====
// Front end: accepts items, tracks orientation and counters, issues store commands.
module mrf_front import mrf_pkg::*; #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned ADDR_W     = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mrf_in_if.sink                in_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DIM_W-1:0]      cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output mrf_meta_t             q_meta_o,
  output logic [ADDR_W-1:0]     q_addr_o,
  output logic [DATA_WIDTH-1:0] q_wdata_o,
  output logic                  loaded_o
);

  localparam int unsigned EFF_MAX = (MAX_DIM < 127) ? MAX_DIM : 127;
  localparam int unsigned POS_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int unsigned IDX_W   = (ADDR_W > 2 * DIM_W) ? ADDR_W : 2 * DIM_W;
  localparam int unsigned DIM_RST = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(EFF_MAX);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_CAP) begin
      res = DIM_CAP;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [DIM_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [ORI_W-1:0] ori_q, ori_d;
  logic [IDX_W-1:0] lc_q, lc_d;
  logic             loaded_q, loaded_d;
  logic [POS_W-1:0] rr_q, rr_d, rc_q, rc_d;

  logic             accept, tr, last, col_wrap;
  logic [IDX_W-1:0] total, lc_base, lc_next, idx;
  logic [DIM_W-1:0] ro, co, i_dim, j_dim;
  logic [POS_W-1:0] r_cur, c_cur, a_sel, b_sel;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign total       = IDX_W'(rows_q) * IDX_W'(cols_q);

  // Map the next output position back to a stored address.
  always_comb begin
    tr       = ori_q[ORI_T];
    ro       = tr ? cols_q : rows_q;
    co       = tr ? rows_q : cols_q;
    r_cur    = (DIM_W'(rr_q) >= ro) ? '0 : rr_q;
    c_cur    = (DIM_W'(rc_q) >= co) ? '0 : rc_q;
    a_sel    = tr ? c_cur : r_cur;
    b_sel    = tr ? r_cur : c_cur;
    i_dim    = ori_q[ORI_FR] ? (rows_q - DIM_W'(1) - DIM_W'(a_sel)) : DIM_W'(a_sel);
    j_dim    = ori_q[ORI_FC] ? (cols_q - DIM_W'(1) - DIM_W'(b_sel)) : DIM_W'(b_sel);
    idx      = IDX_W'(i_dim) * IDX_W'(cols_q) + IDX_W'(j_dim);
    last     = (DIM_W'(r_cur) == ro - DIM_W'(1)) && (DIM_W'(c_cur) == co - DIM_W'(1));
    col_wrap = (DIM_W'(c_cur) + DIM_W'(1)) >= co;
    lc_base  = loaded_q ? '0 : lc_q;
    lc_next  = lc_base + IDX_W'(1);
  end

  always_comb begin
    rows_d   = rows_q;
    cols_d   = cols_q;
    ori_d    = ori_q;
    lc_d     = lc_q;
    loaded_d = loaded_q;
    rr_d     = rr_q;
    rc_d     = rc_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_d = clamp_dim(cfg_data_i);
        CFG_COLS: cols_d = clamp_dim(cfg_data_i);
        default:  ;
      endcase
      ori_d    = '0;
      lc_d     = '0;
      loaded_d = 1'b0;
      rr_d     = '0;
      rc_d     = '0;
    end else if (accept) begin
      case (in_ch.operation)
        OP_LOAD: begin
          if (loaded_q) begin
            ori_d = '0;
            rr_d  = '0;
            rc_d  = '0;
          end
          lc_d     = lc_next;
          loaded_d = (lc_next >= total);
        end
        OP_TRANSFORM: begin
          rr_d = '0;
          rc_d = '0;
          case (in_ch.transform)
            XF_REV_ROWS: ori_d = ori_q ^ (tr ? ORI_M_FC : ORI_M_FR);
            XF_REV_COLS: ori_d = ori_q ^ (tr ? ORI_M_FR : ORI_M_FC);
            XF_ROT90:    ori_d = ori_q ^ ORI_M_T ^ (tr ? ORI_M_FC : ORI_M_FR);
            XF_ROT180:   ori_d = ori_q ^ ORI_M_FR ^ ORI_M_FC;
            XF_ROT270:   ori_d = ori_q ^ ORI_M_T ^ (tr ? ORI_M_FR : ORI_M_FC);
            default: begin
              rr_d = rr_q;
              rc_d = rc_q;
            end
          endcase
        end
        OP_READ: begin
          if (loaded_q) begin
            if (last) begin
              rr_d = '0;
              rc_d = '0;
            end else if (col_wrap) begin
              rr_d = r_cur + POS_W'(1);
              rc_d = '0;
            end else begin
              rr_d = r_cur;
              rc_d = c_cur + POS_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= DIM_W'(DIM_RST);
      cols_q   <= DIM_W'(DIM_RST);
      ori_q    <= '0;
      lc_q     <= '0;
      loaded_q <= 1'b0;
      rr_q     <= '0;
      rc_q     <= '0;
    end else begin
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      ori_q    <= ori_d;
      lc_q     <= lc_d;
      loaded_q <= loaded_d;
      rr_q     <= rr_d;
      rc_q     <= rc_d;
    end
  end

  assign q_push_o = accept && ((in_ch.operation == OP_LOAD) ||
                               ((in_ch.operation == OP_READ) && loaded_q));
  assign q_meta_o.is_read  = (in_ch.operation == OP_READ);
  assign q_meta_o.last     = last;
  assign q_meta_o.out_rows = ro;
  assign q_meta_o.out_cols = co;
  assign q_addr_o = (in_ch.operation == OP_LOAD) ? lc_base[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign loaded_o = loaded_q;

  if (DATA_WIDTH <= VALUE_W) begin : g_wr_trunc
    assign q_wdata_o = in_ch.value[DATA_WIDTH-1:0];
  end else begin : g_wr_ext
    assign q_wdata_o = {{(DATA_WIDTH - VALUE_W){1'b0}}, in_ch.value};
  end

endmodule

// ===== rtl/mrf_back.sv =====
// Back end: matrix store, registered reads and the result register.
module mrf_back import mrf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned ADDR_W     = 12,
  parameter int unsigned MEM_DEPTH  = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrf_q_stat_t           q_stat_i,
  input  mrf_meta_t             head_meta_i,
  input  logic [ADDR_W-1:0]     head_addr_i,
  input  logic [DATA_WIDTH-1:0] head_wdata_i,
  output logic                  q_pop_o,
  mrf_out_if.source             out_ch
);

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  out_valid_q, out_valid_d;
  logic                  last_q;
  logic [DIM_W-1:0]      out_rows_q, out_cols_q;
  logic                  mem_we, mem_re;
  logic [ELEM_W-1:0]     elem;

  // A read may only leave the queue when the result register is free or emptying.
  assign q_pop_o = !q_stat_i.empty &&
                   (!head_meta_i.is_read || !out_valid_q || out_ch.ready);
  assign mem_we  = q_pop_o && !head_meta_i.is_read;
  assign mem_re  = q_pop_o && head_meta_i.is_read;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[head_addr_i] <= head_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q    <= mem[head_addr_i];
      last_q     <= head_meta_i.last;
      out_rows_q <= head_meta_i.out_rows;
      out_cols_q <= head_meta_i.out_cols;
    end
  end

  always_comb begin
    if (mem_re) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  if (DATA_WIDTH >= ELEM_W) begin : g_rd_trunc
    assign elem = rdata_q[ELEM_W-1:0];
  end else begin : g_rd_ext
    assign elem = {{(ELEM_W - DATA_WIDTH){1'b0}}, rdata_q};
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.element  = elem;
  assign out_ch.last     = last_q;
  assign out_ch.out_rows = out_rows_q;
  assign out_ch.out_cols = out_cols_q;

endmodule

// ===== rtl/matrix_rotate_flip_engine.sv =====
// Top level of the matrix rotate and flip engine.
//
// Items arrive on in_ch (valid/ready): a load appends the next element of the
// matrix in row-major order, a transform folds a flip or quarter turn into the
// current orientation, and a read returns the next element of the transformed
// matrix on out_ch together with its last flag and the transformed row and
// column counts. Loads, transforms and reads before the load is complete give
// no result; each read of a complete matrix gives exactly one.
// The block takes one item per cycle while the queue is not full. A read item
// enters the two-entry command queue when accepted; at the queue head, with
// the result register free or emptying, the store's registered read port
// samples it and its result becomes valid. When out_ch stalls, reads collect
// in the queue; once it holds two entries in_ch.ready drops until the receiver
// takes the waiting result. After reset both dimensions are 64 (capped at
// MAX_DIM), the orientation is the identity and no matrix is loaded. Store
// contents are undefined after reset and are never cleared; only elements
// already loaded are ever read. Configuration writes restart loading; the user
// must make them only while the block is idle; the block does not enforce it.
module matrix_rotate_flip_engine import mrf_pkg::*; #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mrf_in_if.sink               in_ch,
  mrf_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

`include "matrix_rotate_flip_engine_assert.svh"

  localparam int unsigned MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned Q_W       = META_W + ADDR_W + DATA_WIDTH;

  // Commands from the front end.
  logic                  f_push;
  mrf_meta_t             f_meta;
  logic [ADDR_W-1:0]     f_addr;
  logic [DATA_WIDTH-1:0] f_wdata;
  logic                  front_loaded;

  // Queue head as seen by the back end.
  logic [Q_W-1:0]        q_din, q_dout;
  mrf_q_stat_t           q_stat;
  logic                  q_pop;
  mrf_meta_t             h_meta;
  logic [ADDR_W-1:0]     h_addr;
  logic [DATA_WIDTH-1:0] h_wdata;

  // The front end owns all command state: dimensions, orientation, load
  // count and read position. Every store access it needs is pushed into the
  // queue with its address already mapped, so the back end never looks at
  // the orientation.
  mrf_front #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_stat.full),
    .q_push_o   (f_push),
    .q_meta_o   (f_meta),
    .q_addr_o   (f_addr),
    .q_wdata_o  (f_wdata),
    .loaded_o   (front_loaded)
  );

  assign q_din = {f_meta, f_addr, f_wdata};

  // The queue keeps writes and reads in order, so a read always sees every
  // load accepted before it.
  mrf_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i (q_din),
    .pop_i  (q_pop),
    .data_o (q_dout),
    .stat_o (q_stat)
  );

  assign {h_meta, h_addr, h_wdata} = q_dout;

  // The back end performs one store access per cycle while the queue can pop
  // and holds the result register; the registered store read is the result.
  mrf_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .head_meta_i  (h_meta),
    .head_addr_i  (h_addr),
    .head_wdata_i (h_wdata),
    .q_pop_o      (q_pop),
    .out_ch       (out_ch)
  );

  // A configuration write always leaves the matrix unloaded.
  `MRF_ASSERT_NEXT(a_cfg_restarts, cfg_we_i, !front_loaded, "configuration write left matrix loaded")
  // The back end never takes a command from an empty queue.
  `MRF_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "queue popped while empty")
  // A full queue must hold off new items.
  `MRF_ASSERT_NOW(a_full_backpressure, q_stat.full, !in_ch.ready, "item accepted into full queue")

endmodule

// ===== tb/matrix_rotate_flip_engine_tb.sv =====
// Self-checking testbench for the matrix rotate and flip engine.
module matrix_rotate_flip_engine_tb;
  import mrf_pkg::*;

  // Geometry of the instance under test.
  localparam int unsigned MAX_DIM    = 64;
  localparam int unsigned STORE_SIZE = MAX_DIM * MAX_DIM;

  // Operation code that the block must ignore; the package names only three.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  // Highest transform code the field can carry; codes above rotate 270 are ignored.
  localparam logic [XF_W-1:0] XF_TOP = {XF_W{1'b1}};

  localparam int unsigned MAX_WAIT       = 4;    // longest idle or stall per item
  localparam int unsigned SETTLE_CYCLES  = 4;    // lets loads still queued reach the store
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned RANDOM_ITEMS   = 150;

  // One element of the transformed matrix as it should appear on the output.
  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic [DIM_W-1:0]         out_rows;
    logic [DIM_W-1:0]         out_cols;
  } elem_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_data_i;

  mrf_in_if  in_ch ();
  mrf_out_if out_ch ();

  matrix_rotate_flip_engine #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (ELEM_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block: the register values, the stored matrix and the
  // folded orientation, with the row-major read position of the output.
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  logic signed [ELEM_W-1:0] matrix_mem [STORE_SIZE];
  logic [ORI_W-1:0]         orient;
  int unsigned              load_cnt;
  bit                       loaded;
  int unsigned              rd_row;
  int unsigned              rd_col;

  // Elements that reads have asked for and that have not come out yet.
  elem_result_t pending_reads[$];

  int unsigned mismatches;
  int unsigned counted_items;  // items that the block does not simply ignore
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          steady_feed;    // sender runs without gaps while set
  bit          eager_sink;     // receiver takes every result at once while set

  // A dimension of zero behaves as one, and anything above the store's side
  // behaves as the full side.
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void restart_matrix();
    orient   = '0;
    load_cnt = 0;
    loaded   = 1'b0;
    rd_row   = 0;
    rd_col   = 0;
  endfunction

  // Every flip and quarter turn is folded into the transpose, row-flip and
  // column-flip bits. Once transposed, the output rows are the stored columns,
  // so a flip of output rows lands on the column-flip bit and vice versa.
  function automatic void fold_transform(logic [XF_W-1:0] xf);
    case (xf)
      XF_REV_ROWS: begin
        orient ^= orient[ORI_T] ? ORI_M_FC : ORI_M_FR;
      end
      XF_REV_COLS: begin
        orient ^= orient[ORI_T] ? ORI_M_FR : ORI_M_FC;
      end
      XF_ROT90: begin
        orient ^= ORI_M_T;
        orient ^= orient[ORI_T] ? ORI_M_FR : ORI_M_FC;
      end
      XF_ROT180: begin
        orient ^= ORI_M_FR | ORI_M_FC;
      end
      XF_ROT270: begin
        orient ^= ORI_M_T;
        orient ^= orient[ORI_T] ? ORI_M_FC : ORI_M_FR;
      end
      default: return;
    endcase
    rd_row = 0;
    rd_col = 0;
  endfunction

  // Updates the shadow for one accepted item and queues the element that a
  // read of a complete matrix must return.
  function automatic void track_command(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                                        logic [XF_W-1:0] xf);
    int unsigned  nr, nc, ro, co, r, c, a, b, i, j;
    bit           tr;
    elem_result_t res;
    nr = eff_dim(rows_reg);
    nc = eff_dim(cols_reg);
    case (op)
      OP_LOAD: begin
        if (loaded) restart_matrix();
        if (load_cnt < nr * nc) matrix_mem[load_cnt] = val;
        load_cnt++;
        if (load_cnt >= nr * nc) loaded = 1'b1;
      end
      OP_TRANSFORM: begin
        fold_transform(xf);
      end
      OP_READ: begin
        if (loaded) begin
          tr = orient[ORI_T];
          ro = tr ? nc : nr;
          co = tr ? nr : nc;
          r  = (rd_row >= ro) ? 0 : rd_row;
          c  = (rd_col >= co) ? 0 : rd_col;
          // Map the output address back to the stored row and column.
          a  = tr ? c : r;
          b  = tr ? r : c;
          i  = orient[ORI_FR] ? nr - 1 - a : a;
          j  = orient[ORI_FC] ? nc - 1 - b : b;
          res.element  = matrix_mem[(i * nc + j) % STORE_SIZE];
          res.last     = (r == ro - 1) && (c == co - 1);
          res.out_rows = DIM_W'(ro);
          res.out_cols = DIM_W'(co);
          pending_reads.push_back(res);
          if (res.last) begin
            rd_row = 0;
            rd_col = 0;
          end else if (c + 1 >= co) begin
            rd_row = r + 1;
            rd_col = 0;
          end else begin
            rd_row = r;
            rd_col = c + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compares one accepted result with the oldest element still owed.
  function automatic void check_result();
    elem_result_t exp_r;
    if (pending_reads.size() == 0) begin
      mismatches++;
      $display("%0t: result with no read outstanding: expected none, actual element %0d",
               $time, out_ch.element);
      return;
    end
    exp_r = pending_reads.pop_front();
    if (out_ch.element !== exp_r.element) begin
      mismatches++;
      $display("%0t: element: expected %0d, actual %0d", $time, exp_r.element,
               out_ch.element);
    end
    if (out_ch.last !== exp_r.last) begin
      mismatches++;
      $display("%0t: last: expected %0b, actual %0b", $time, exp_r.last, out_ch.last);
    end
    if (out_ch.out_rows !== exp_r.out_rows) begin
      mismatches++;
      $display("%0t: out_rows: expected %0d, actual %0d", $time, exp_r.out_rows,
               out_ch.out_rows);
    end
    if (out_ch.out_cols !== exp_r.out_cols) begin
      mismatches++;
      $display("%0t: out_cols: expected %0d, actual %0d", $time, exp_r.out_cols,
               out_ch.out_cols);
    end
  endfunction

  // Result receiver. After each result it may hold ready low for a drawn
  // number of cycles; now and then it switches to taking results at once.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        if ($urandom_range(0, 31) == 0) eager_sink = !eager_sink;
        hold_left = eager_sink ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold_left != 0) begin
          out_ch.ready <= 1'b0;
          hold_left--;
        end
      end else if (!out_ch.ready) begin
        if (hold_left == 0) out_ch.ready <= 1'b1;
        else hold_left--;
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long has
  // hung, whether in the block or in a wait for a result that never comes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one item after a drawn gap and returns once it has been taken.
  // Valid stays high after acceptance, so back-to-back items need no second
  // assignment to it in the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [XF_W-1:0] xf);
    int unsigned gap;
    if ($urandom_range(0, 47) == 0) steady_feed = !steady_feed;
    gap = steady_feed ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.transform <= xf;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    track_command(op, val, xf);
    if (op != OP_NONE && !(op == OP_TRANSFORM && xf > XF_ROT270)) counted_items++;
  endtask

  // The fields that an operation does not use carry random bits throughout.
  task automatic send_load(input logic [VALUE_W-1:0] val);
    send_item(OP_LOAD, val, XF_W'($urandom_range(0, XF_TOP)));
  endtask

  task automatic send_transform(input logic [XF_W-1:0] xf);
    send_item(OP_TRANSFORM, $urandom, xf);
  endtask

  task automatic send_read();
    send_item(OP_READ, $urandom, XF_W'($urandom_range(0, XF_TOP)));
  endtask

  // Stops offering items, waits for every owed element and then lets the
  // pipeline run dry, since loads and transforms in flight give no result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle; each restarts loading.
  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = data;
    else cols_reg = data;
    restart_matrix();
  endtask

  // Out of reset the matrix is 64 by 64, so a short run of loads leaves it
  // incomplete: every read before and after them, and after a turn, must
  // stay silent.
  task automatic test_default_geometry();
    repeat (8) send_read();
    repeat (32) send_load($urandom);
    send_transform(XF_ROT90);
    repeat (8) send_read();
  endtask

  // A 2 by 3 matrix with the value extremes: a read before the load is
  // complete, a turn in the middle of loading, a full pass with its wrap,
  // the ignored codes, each transform with the read position it resets,
  // and a load after completion that begins a new matrix.
  task automatic test_directed();
    write_dim(CFG_ROWS, 7'd2);
    write_dim(CFG_COLS, 7'd3);
    send_read();
    send_load(32'h8000_0000);
    send_load(32'h7FFF_FFFF);
    send_transform(XF_ROT90);
    send_load(32'h0000_0000);
    send_load(32'hFFFF_FFFF);
    send_load(32'h5555_5555);
    send_load(32'hAAAA_AAAA);
    repeat (7) send_read();
    send_transform(XF_TOP);
    send_item(OP_NONE, $urandom, XF_W'($urandom_range(0, XF_TOP)));
    send_transform(XF_REV_ROWS);
    send_read();
    send_transform(XF_REV_COLS);
    send_read();
    send_transform(XF_ROT180);
    send_read();
    send_transform(XF_ROT270);
    send_read();
    send_load($urandom);
    send_read();
  endtask

  // Register values at and beyond the legal range: zero acts as one and
  // anything above the side of the store acts as the full side.
  task automatic test_dimension_limits();
    logic [DIM_W-1:0] lim_rows [4] = '{7'd0, 7'd64, 7'd127, 7'd1};
    logic [DIM_W-1:0] lim_cols [4] = '{7'd127, 7'd0, 7'd1, 7'd1};
    int unsigned      total;
    for (int k = 0; k < 4; k++) begin
      write_dim(CFG_ROWS, lim_rows[k]);
      write_dim(CFG_COLS, lim_cols[k]);
      total = eff_dim(lim_rows[k]) * eff_dim(lim_cols[k]);
      repeat (total) send_load($urandom);
      send_transform(XF_W'($urandom_range(0, XF_ROT270)));
      repeat (total + 1) send_read();
      send_transform(XF_W'($urandom_range(0, XF_ROT270)));
      repeat (3) send_read();
    end
  endtask

  // Random phases. Most load a complete matrix of random shape, with the odd
  // transform or early read mixed in, and then read and transform at random.
  // The rest break off the load part way, so their reads must stay silent.
  // Large shapes are kept rare and paired with a thin other side.
  task automatic test_random_sequences();
    int unsigned      goal, total, n_load, len, pick;
    logic [DIM_W-1:0] new_rows, new_cols;
    goal = counted_items + RANDOM_ITEMS;
    while (counted_items < goal) begin
      case ($urandom_range(0, 11))
        0:       new_rows = '0;
        1:       new_rows = {DIM_W{1'b1}};
        2:       new_rows = DIM_W'($urandom_range(MAX_DIM - 4, MAX_DIM + 8));
        default: new_rows = DIM_W'($urandom_range(1, 8));
      endcase
      if (eff_dim(new_rows) > 8) new_cols = DIM_W'($urandom_range(0, 3));
      else if ($urandom_range(0, 9) == 0) new_cols = {DIM_W{1'b1}};
      else new_cols = DIM_W'($urandom_range(0, 8));
      if ($urandom_range(0, 3) != 0 || eff_dim(new_rows) * eff_dim(cols_reg) > 64) begin
        write_dim(CFG_ROWS, new_rows);
        write_dim(CFG_COLS, new_cols);
      end else begin
        write_dim(CFG_ROWS, new_rows);
      end
      total  = eff_dim(rows_reg) * eff_dim(cols_reg);
      n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
      for (int k = 0; k < n_load; k++) begin
        if ($urandom_range(0, 9) == 0) send_transform(XF_W'($urandom_range(0, XF_TOP)));
        if ($urandom_range(0, 19) == 0) send_read();
        send_load($urandom);
      end
      len = (total > 28) ? 60 : $urandom_range(total, 2 * total + 4);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          send_read();
        end else if (pick < 17) begin
          send_transform(XF_W'($urandom_range(0, XF_ROT270)));
        end else if (pick == 17) begin
          send_transform(XF_W'($urandom_range(XF_ROT270 + 1, XF_TOP)));
        end else if (pick == 18) begin
          send_item(OP_NONE, $urandom, XF_W'($urandom_range(0, XF_TOP)));
        end else if (total <= 64) begin
          // Reloading a complete matrix starts it afresh.
          repeat (total) send_load($urandom);
        end else begin
          send_load($urandom);
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ROWS;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.value     = '0;
    in_ch.transform = XF_REV_ROWS;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    counted_items   = 0;
    quiet_cycles    = 0;
    hold_left       = 0;
    steady_feed     = 1'b0;
    eager_sink      = 1'b0;
    rows_reg        = DIM_W'(MAX_DIM);
    cols_reg        = DIM_W'(MAX_DIM);
    restart_matrix();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_geometry();
    test_directed();
    test_dimension_limits();
    test_random_sequences();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
